// File: hdl/cbr_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and register codes for the combination-by-rank block.
// No dependencies; every other file takes names from here by scope.
package cbr_pkg;

    localparam int N_W        = 7;   // set_size
    localparam int K_W        = 5;   // choose_k
    localparam int RANK_W     = 32;
    localparam int ELEM_W     = 6;
    localparam int POS_W      = 4;
    localparam int BIN_W      = RANK_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Binomials saturate here, one above the largest rank.
    localparam logic [BIN_W-1:0] RANK_CAP = {1'b1, {RANK_W{1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHOOSE_K = 2'd1;

endpackage

// File: hdl/cbr_rank_if.sv
`timescale 1ns / 1ps
// Request channel: one word carries the wanted rank.
// Depends on cbr_pkg for the field width.
interface cbr_rank_if;
    logic                        valid;
    logic                        ready;
    logic [cbr_pkg::RANK_W-1:0]  rank_index;

    modport source (output valid, output rank_index, input ready);
    modport sink   (input valid, input rank_index, output ready);
endinterface

// File: hdl/cbr_res_if.sv
`timescale 1ns / 1ps
// Result channel: one word per element of the combination, or one miss word.
// Depends on cbr_pkg for the field widths.
interface cbr_res_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [cbr_pkg::ELEM_W-1:0]  element;
    logic [cbr_pkg::POS_W-1:0]   position;
    logic                        last;

    modport source (output valid, output found, output element, output position,
                    output last, input ready);
    modport sink   (input valid, input found, input element, input position,
                    input last, output ready);
endinterface

// File: hdl/cbr_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on cbr_pkg for the field widths.
interface cbr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cbr_pkg::CFG_IDX_W-1:0]   index;
    logic [cbr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/combination_by_rank_top.sv
`timescale 1ns / 1ps
// Combination-by-rank top level: binomial table memory, unranking sequencer,
// output register. Depends on cbr_pkg, cbr_rank_if, cbr_res_if, cbr_cfg_if.
//
//  channel  | dir | words                 | payload
//  ---------+-----+-----------------------+--------------------------------
//  i_rank   | in  | one per request       | rank_index
//  o_res    | out | max(k,1) hit, 1 miss  | found, element, position, last
//  i_cfg    | in  | one per register      | index, data (set_size, choose_k)
//
// After reset the binomial table is built, one entry per S_FILL step, with an extra
// S_FILL_SUM step for each entry with row and column above zero; no request is
// taken then. A hit steps through S_TOTAL and then, per element, a lookup (S_LOOK)
// and compare (S_CMP) for each block tried and an emit (S_EMIT), serialised by the
// one table read port; a miss leaves through S_SINGLE, straight from idle or after
// S_TOTAL.
// Results stall in the output register; the next request is taken while the
// final word waits there.
module combination_by_rank_top #(
    parameter int MAX_ITEMS  = 64,
    parameter int MAX_CHOOSE = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cbr_rank_if.sink   i_rank,
    cbr_res_if.source  o_res,
    cbr_cfg_if.sink    i_cfg
);

    localparam int COLS   = MAX_CHOOSE + 1;
    localparam int DEPTH  = (MAX_ITEMS + 1) * COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int A_W    = (MAX_ITEMS > 0) ? $clog2(MAX_ITEMS + 1) : 1;
    localparam int B_W    = (MAX_CHOOSE > 0) ? $clog2(MAX_CHOOSE + 1) : 1;

    typedef enum logic [7:0] {
        S_FILL     = 8'b0000_0001,
        S_FILL_SUM = 8'b0000_0010,
        S_IDLE     = 8'b0000_0100,
        S_TOTAL    = 8'b0000_1000,
        S_LOOK     = 8'b0001_0000,
        S_CMP      = 8'b0010_0000,
        S_EMIT     = 8'b0100_0000,
        S_SINGLE   = 8'b1000_0000
    } t_state;

    // binomial table, C(a,b) at a*COLS+b
    logic [cbr_pkg::BIN_W-1:0]  r_binom [DEPTH];
    logic [cbr_pkg::BIN_W-1:0]  r_mem_q;

    t_state                       r_state, n_state;
    logic [cbr_pkg::N_W-1:0]      r_set_size;
    logic [cbr_pkg::K_W-1:0]      r_choose_k;
    logic [cbr_pkg::RANK_W-1:0]   r_rank, n_rank;
    logic [cbr_pkg::N_W-1:0]      r_c, n_c;
    logic [cbr_pkg::K_W-1:0]      r_p, n_p;
    logic                         r_single_found, n_single_found;
    logic [A_W-1:0]               r_fa, n_fa;
    logic [B_W-1:0]               r_fb, n_fb;
    logic [ADDR_W-1:0]            r_faddr, n_faddr;
    logic [cbr_pkg::BIN_W-1:0]    r_left, n_left;

    logic                         r_out_valid, n_out_valid;
    logic                         r_out_found, n_out_found;
    logic [cbr_pkg::ELEM_W-1:0]   r_out_elem, n_out_elem;
    logic [cbr_pkg::POS_W-1:0]    r_out_pos, n_out_pos;
    logic                         r_out_last, n_out_last;

    logic                         w_we;
    logic [ADDR_W-1:0]            w_waddr;
    logic [ADDR_W-1:0]            w_raddr;
    logic [cbr_pkg::BIN_W-1:0]    w_wdata;
    logic [cbr_pkg::BIN_W:0]      w_sum;
    logic                         w_bad;
    logic                         w_slot_free;
    logic                         w_last_pos;
    logic [cbr_pkg::N_W-1:0]      w_row;
    logic [cbr_pkg::K_W-1:0]      w_col;
    logic [ADDR_W-1:0]            w_look_addr;
    logic [ADDR_W-1:0]            w_total_addr;

    assign i_rank.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign o_res.valid    = r_out_valid;
    assign o_res.found    = r_out_found;
    assign o_res.element  = r_out_elem;
    assign o_res.position = r_out_pos;
    assign o_res.last     = r_out_last;

    assign w_slot_free = !r_out_valid || o_res.ready;

    assign w_bad = (r_set_size == '0)
                || (int'(r_set_size) > MAX_ITEMS)
                || (int'(r_choose_k) > MAX_CHOOSE)
                || ({2'b00, r_choose_k} > r_set_size);

    assign w_row        = r_set_size - r_c - cbr_pkg::N_W'(1);
    assign w_col        = r_choose_k - r_p - cbr_pkg::K_W'(1);
    assign w_look_addr  = ADDR_W'(ADDR_W'(w_row) * ADDR_W'(COLS)) + ADDR_W'(w_col);
    assign w_total_addr = ADDR_W'(ADDR_W'(r_set_size) * ADDR_W'(COLS))
                        + ADDR_W'(r_choose_k);
    assign w_last_pos   = ((r_p + cbr_pkg::K_W'(1)) == r_choose_k);
    assign w_sum        = {1'b0, r_left} + {1'b0, r_mem_q};

    always_comb begin
        n_state        = r_state;
        n_rank         = r_rank;
        n_c            = r_c;
        n_p            = r_p;
        n_single_found = r_single_found;
        n_fa           = r_fa;
        n_fb           = r_fb;
        n_faddr        = r_faddr;
        n_left         = r_left;
        n_out_valid    = r_out_valid && !o_res.ready;
        n_out_found    = r_out_found;
        n_out_elem     = r_out_elem;
        n_out_pos      = r_out_pos;
        n_out_last     = r_out_last;
        w_we           = 1'b0;
        w_waddr        = r_faddr;
        w_wdata        = '0;
        w_raddr        = r_faddr - ADDR_W'(COLS);

        unique case (r_state)
            S_FILL: begin
                if ((r_fa == '0) || (r_fb == '0)) begin
                    w_we    = 1'b1;
                    w_wdata = (r_fb == '0) ? cbr_pkg::BIN_W'(1) : '0;
                    n_left  = cbr_pkg::BIN_W'(1);
                    n_faddr = r_faddr + ADDR_W'(1);
                    if (r_fb == B_W'(MAX_CHOOSE)) begin
                        n_fb = '0;
                        n_fa = r_fa + A_W'(1);
                        if (r_fa == A_W'(MAX_ITEMS)) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_fb = r_fb + B_W'(1);
                    end
                end else begin
                    // read C(a-1,b) from the row above
                    n_state = S_FILL_SUM;
                end
            end
            S_FILL_SUM: begin
                w_we    = 1'b1;
                w_wdata = (w_sum > {1'b0, cbr_pkg::RANK_CAP}) ? cbr_pkg::RANK_CAP
                                                           : w_sum[cbr_pkg::BIN_W-1:0];
                n_left  = r_mem_q;
                n_faddr = r_faddr + ADDR_W'(1);
                n_state = S_FILL;
                if (r_fb == B_W'(MAX_CHOOSE)) begin
                    n_fb = '0;
                    n_fa = r_fa + A_W'(1);
                    if (r_fa == A_W'(MAX_ITEMS)) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_fb = r_fb + B_W'(1);
                end
            end
            S_IDLE: begin
                w_raddr = w_total_addr;
                if (i_rank.valid) begin
                    n_rank = i_rank.rank_index;
                    n_c    = '0;
                    n_p    = '0;
                    if (w_bad) begin
                        n_single_found = 1'b0;
                        n_state        = S_SINGLE;
                    end else begin
                        n_state = S_TOTAL;
                    end
                end
            end
            S_TOTAL: begin
                if ({1'b0, r_rank} >= r_mem_q) begin
                    n_single_found = 1'b0;
                    n_state        = S_SINGLE;
                end else if (r_choose_k == '0) begin
                    n_single_found = 1'b1;
                    n_state        = S_SINGLE;
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                w_raddr = w_look_addr;
                if (({1'b0, r_c} + 8'd1) < {1'b0, r_set_size}) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_CMP: begin
                if ({1'b0, r_rank} < r_mem_q) begin
                    n_state = S_EMIT;
                end else begin
                    // skip the whole block that starts with this element
                    n_rank  = r_rank - r_mem_q[cbr_pkg::RANK_W-1:0];
                    n_c     = r_c + cbr_pkg::N_W'(1);
                    n_state = S_LOOK;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = 1'b1;
                    n_out_elem  = r_c[cbr_pkg::ELEM_W-1:0];
                    n_out_pos   = r_p[cbr_pkg::POS_W-1:0];
                    n_out_last  = w_last_pos;
                    n_c         = r_c + cbr_pkg::N_W'(1);
                    n_p         = r_p + cbr_pkg::K_W'(1);
                    n_state     = w_last_pos ? S_IDLE : S_LOOK;
                end
            end
            S_SINGLE: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_single_found;
                    n_out_elem  = '0;
                    n_out_pos   = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_binom[w_waddr] <= w_wdata;
        end
        r_mem_q <= r_binom[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_fa        <= '0;
            r_fb        <= '0;
            r_faddr     <= '0;
            r_out_valid <= 1'b0;
            r_set_size  <= '0;
            r_choose_k  <= '0;
        end else begin
            r_state     <= n_state;
            r_fa        <= n_fa;
            r_fb        <= n_fb;
            r_faddr     <= n_faddr;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                if (i_cfg.index == cbr_pkg::REG_SET_SIZE) begin
                    r_set_size <= i_cfg.data;
                end else if (i_cfg.index == cbr_pkg::REG_CHOOSE_K) begin
                    r_choose_k <= i_cfg.data[cbr_pkg::K_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank         <= n_rank;
        r_c            <= n_c;
        r_p            <= n_p;
        r_single_found <= n_single_found;
        r_left         <= n_left;
        r_out_found    <= n_out_found;
        r_out_elem     <= n_out_elem;
        r_out_pos      <= n_out_pos;
        r_out_last     <= n_out_last;
    end

    // a miss is one word with zero fields
    a_miss_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.found) |-> (o_res.last && o_res.element == '0
                                           && o_res.position == '0))
        else $error("miss word is not a single zero word");

    // no result right after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");

    // a word that is not last lies before the final position
    a_last_at_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.found && !o_res.last)
            |-> ({1'b0, o_res.position} + 5'd1 < r_choose_k))
        else $error("early word at or past final position");

    // no request is taken while the table is being built
    a_fill_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL || r_state == S_FILL_SUM) |-> !i_rank.ready)
        else $error("request ready during table build");

endmodule

// File: dv/combination_by_rank_top_tb.sv
`timescale 1ns / 1ps
// Testbench for combination_by_rank_top: drives rank requests and register writes, predicts
// the word stream of each combination and checks it word by word.
// Depends on cbr_pkg, the three channel interfaces and the top level in hdl.
module combination_by_rank_top_tb;

    localparam int ITEMS_MAX       = 64;
    localparam int CHOOSE_MAX      = 16;
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int PHASE_ITEMS     = 56;
    localparam int RANDOM_PHASES   = 8;
    // Indexes that hold no register; a write there must change nothing.
    localparam logic [cbr_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [cbr_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic                       found;
        logic [cbr_pkg::ELEM_W-1:0] element;
        logic [cbr_pkg::POS_W-1:0]  position;
        logic                       last;
    } t_combo_word;

    logic i_clk;
    logic i_rst_n;

    cbr_rank_if rank_ch();
    cbr_res_if  res_ch();
    cbr_cfg_if  cfg_ch();

    combination_by_rank_top #(
        .MAX_ITEMS  (ITEMS_MAX),
        .MAX_CHOOSE (CHOOSE_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rank  (rank_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    longint unsigned binom_sat [0:ITEMS_MAX][0:CHOOSE_MAX];
    logic [cbr_pkg::N_W-1:0]    set_size_cfg;
    logic [cbr_pkg::K_W-1:0]    choose_k_cfg;
    logic [cbr_pkg::RANK_W-1:0] pending_ranks[$];
    t_combo_word     expected_words[$];
    int              send_idle_pct;
    int              recv_stall_pct;
    int              error_count = 0;
    int              cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Number of combinations under the current registers, 0 when unsupported.
    function automatic longint unsigned combo_count();
        if (set_size_cfg == 0 || set_size_cfg > ITEMS_MAX || choose_k_cfg > CHOOSE_MAX) begin
            return 0;
        end
        return binom_sat[set_size_cfg][choose_k_cfg];
    endfunction

    function automatic void predict_combination(input logic [cbr_pkg::RANK_W-1:0] rank);
        longint unsigned remaining;
        longint unsigned block;
        int unsigned     n;
        int unsigned     k;
        int unsigned     c;
        t_combo_word     word;
        n = set_size_cfg;
        k = choose_k_cfg;
        remaining = rank;
        if (combo_count() == 0 || remaining >= combo_count()) begin
            word = '{found: 1'b0, element: '0, position: '0, last: 1'b1};
            expected_words.push_back(word);
            return;
        end
        if (k == 0) begin
            word = '{found: 1'b1, element: '0, position: '0, last: 1'b1};
            expected_words.push_back(word);
            return;
        end
        // Skip whole blocks of combinations that start with a smaller element.
        c = 0;
        for (int unsigned p = 0; p < k; p++) begin
            while (c + 1 < n) begin
                block = binom_sat[n - 1 - c][k - 1 - p];
                if (remaining < block) break;
                remaining -= block;
                c++;
            end
            word.found    = 1'b1;
            word.element  = c[cbr_pkg::ELEM_W-1:0];
            word.position = p[cbr_pkg::POS_W-1:0];
            word.last     = (p + 1 == k);
            expected_words.push_back(word);
            c++;
        end
    endfunction

    // Leaves valid high; close a burst of writes with end_writes.
    task automatic write_reg(input logic [cbr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cbr_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            cbr_pkg::REG_SET_SIZE: set_size_cfg = val[cbr_pkg::N_W-1:0];
            cbr_pkg::REG_CHOOSE_K: choose_k_cfg = val[cbr_pkg::K_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [cbr_pkg::CFG_DATA_W-1:0] n_val,
                              input logic [cbr_pkg::CFG_DATA_W-1:0] k_val);
        write_reg(cbr_pkg::REG_SET_SIZE, n_val);
        write_reg(cbr_pkg::REG_CHOOSE_K, k_val);
        end_writes();
    endtask

    task automatic wait_drained;
        do @(posedge i_clk);
        while (pending_ranks.size() != 0 || rank_ch.valid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver: present the next pending rank, hold it until taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rank_ch.valid <= 1'b0;
        end else begin
            if (rank_ch.valid && rank_ch.ready) begin
                predict_combination(rank_ch.rank_index);
            end
            if (!rank_ch.valid || rank_ch.ready) begin
                if (pending_ranks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    rank_ch.valid      <= 1'b1;
                    rank_ch.rank_index <= pending_ranks.pop_front();
                end else begin
                    rank_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare every taken word with the oldest expected one.
    always @(posedge i_clk) begin : result_check
        t_combo_word want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word found=%0d element=%0d position=%0d last=%0d",
                             $time, res_ch.found, res_ch.element, res_ch.position,
                             res_ch.last);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (res_ch.found !== want.found || res_ch.element !== want.element ||
                        res_ch.position !== want.position || res_ch.last !== want.last) begin
                        $display("%0t: word mismatch, expected found=%0d element=%0d %s%0d %s%0d",
                                 $time, want.found, want.element, "position=",
                                 want.position, "last=", want.last);
                        $display("%0t:                got found=%0d element=%0d %s%0d %s%0d",
                                 $time, res_ch.found, res_ch.element, "position=",
                                 res_ch.position, "last=", res_ch.last);
                        error_count++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[combination_by_rank_top] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        longint unsigned total;
        logic [cbr_pkg::RANK_W-1:0] start;
        logic [cbr_pkg::CFG_DATA_W-1:0] n_val;
        logic [cbr_pkg::CFG_DATA_W-1:0] k_val;
        int unsigned sel;
        int unsigned run_len;
        int pushed;
        bit paused;

        for (int a = 0; a <= ITEMS_MAX; a++) begin
            binom_sat[a][0] = 1;
            for (int b = 1; b <= CHOOSE_MAX; b++) begin
                total = (a > 0) ? binom_sat[a-1][b-1] + binom_sat[a-1][b] : 0;
                // Saturate one above the largest rank.
                binom_sat[a][b] = (total > 64'h1_0000_0000) ? 64'h1_0000_0000 : total;
            end
        end
        set_size_cfg   = '0;
        choose_k_cfg   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty set with the registers at their reset values.
        pending_ranks.push_back(32'd0);
        pending_ranks.push_back(32'hFFFF_FFFF);
        wait_drained();
        // Largest set and size: every rank exists.
        set_config(7'd64, 7'd16);
        pending_ranks.push_back(32'd0);
        pending_ranks.push_back(32'hFFFF_FFFF);
        pending_ranks.push_back(32'h8000_0000);
        wait_drained();
        // Empty combination: only rank 0.
        set_config(7'd64, 7'd0);
        pending_ranks.push_back(32'd0);
        pending_ranks.push_back(32'd1);
        wait_drained();
        // Size above set: no combinations.
        set_config(7'd5, 7'd7);
        pending_ranks.push_back(32'd0);
        wait_drained();
        // Set beyond the supported item count.
        set_config(7'd127, 7'd2);
        pending_ranks.push_back(32'd0);
        wait_drained();
        // Size beyond the supported maximum; the upper data bits drop.
        set_config(7'd64, 7'h7F);
        pending_ranks.push_back(32'd0);
        wait_drained();
        // Small set: first, final, past end, then a step back.
        set_config(7'd6, 7'd3);
        write_reg(REG_UNUSED_A, 7'h55);
        write_reg(REG_UNUSED_B, 7'h2A);
        end_writes();
        pending_ranks.push_back(32'd0);
        pending_ranks.push_back(32'd19);
        pending_ranks.push_back(32'd20);
        pending_ranks.push_back(32'd5);
        pending_ranks.push_back(32'd3);
        wait_drained();
        set_config(7'd64, 7'd1);
        pending_ranks.push_back(32'd63);
        pending_ranks.push_back(32'd64);
        wait_drained();
        set_config(7'd1, 7'd1);
        pending_ranks.push_back(32'd0);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin n_val = 7'd64; k_val = 7'd16; end
                1: begin n_val = 7'd64; k_val = 7'($urandom_range(1, 3)); end
                2: begin
                    n_val = 7'($urandom_range(1, 20));
                    k_val = 7'($urandom_range(0, (n_val > 16) ? 16 : n_val));
                end
                3: begin n_val = 7'($urandom_range(1, 64)); k_val = 7'($urandom_range(0, 16)); end
                4: begin n_val = 7'd16; k_val = 7'd8; end
                5: begin
                    n_val = 7'($urandom_range(1, 12));
                    k_val = n_val - 7'($urandom_range(0, 1));
                end
                6: begin n_val = 7'd64; k_val = 7'($urandom_range(4, 16)); end
                default: begin n_val = 7'($urandom()); k_val = 7'($urandom()); end
            endcase
            set_config(n_val, k_val);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            total = combo_count();
            pushed = 0;
            paused = 0;
            while (pushed < PHASE_ITEMS) begin
                // Hold the requests halfway until every word has come back.
                if (!paused && pushed >= PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1;
                end
                if (total == 0) begin
                    pending_ranks.push_back($urandom_range(0, 1) ? $urandom() : 32'd0);
                    pushed++;
                end else begin
                    sel = $urandom_range(0, 9);
                    if (sel <= 4) begin
                        // Walk neighboring ranks, mostly upward.
                        run_len = $urandom_range(2, 6);
                        start = $urandom_range(0, 32'(total - 1));
                        for (int unsigned i = 0; i < run_len; i++) begin
                            pending_ranks.push_back((sel == 4) ? start - i : start + i);
                        end
                        pushed += run_len;
                    end else begin
                        case (sel)
                            5, 6: pending_ranks.push_back($urandom_range(0, 32'(total - 1)));
                            7: begin
                                case ($urandom_range(0, 2))
                                    0: pending_ranks.push_back(32'd0);
                                    1: pending_ranks.push_back(32'(total - 1));
                                    default: pending_ranks.push_back(32'(total));
                                endcase
                            end
                            default: pending_ranks.push_back($urandom());
                        endcase
                        pushed++;
                    end
                end
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("[combination_by_rank_top] OK");
        end else begin
            $display("[combination_by_rank_top] ERROR");
        end
        $finish;
    end
endmodule

// File: combination_by_rank_top.f
hdl/cbr_pkg.sv
hdl/cbr_rank_if.sv
hdl/cbr_res_if.sv
hdl/cbr_cfg_if.sv
hdl/combination_by_rank_top.sv
dv/combination_by_rank_top_tb.sv
